@@ rtl/fifo_queue_with_delete_macros.svh @@
// ----------------------------------------------------------------------------
// fifo queue with delete - assertion macros
// concurrent property wrappers, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef FIFO_QUEUE_WITH_DELETE_MACROS_SVH
`define FIFO_QUEUE_WITH_DELETE_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define FQD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fqd assertion failed");

// next-cycle implication
`define FQD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fqd assertion failed");

`else

`define FQD_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define FQD_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/fqd_pkg.sv @@
// ----------------------------------------------------------------------------
// fqd_pkg
// shared constants, request codes and the result beat type
// ----------------------------------------------------------------------------
package fqd_pkg;

    localparam int FQD_DEPTH      = 16;
    localparam int FQD_DATA_WIDTH = 32;

    localparam int REQ_W   = 3;
    localparam int ITEM_W  = 32;
    localparam int COUNT_W = 5;

    localparam logic [REQ_W-1:0] REQ_ENQUEUE = 3'd0;
    localparam logic [REQ_W-1:0] REQ_DEQUEUE = 3'd1;
    localparam logic [REQ_W-1:0] REQ_DELETE  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_ITERATE = 3'd3;
    localparam logic [REQ_W-1:0] REQ_LENGTH  = 3'd4;

    typedef struct packed {
        logic               status;
        logic               item_valid;
        logic [ITEM_W-1:0]  item_data;
        logic [COUNT_W-1:0] entry_count;
        logic               last;
    } fqd_res_t;

    function automatic int fqd_ptr_w(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

    function automatic int fqd_cnt_w(input int depth);
        return $clog2(depth + 1);
    endfunction

endpackage

@@ rtl/fqd_store.sv @@
// ----------------------------------------------------------------------------
// fqd_store
// entry memory: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module fqd_store #(
    parameter int DEPTH      = fqd_pkg::FQD_DEPTH,
    parameter int DATA_WIDTH = fqd_pkg::FQD_DATA_WIDTH
) (
    input  logic                                    clk,
    input  logic                                    wr_en,
    input  logic [fqd_pkg::fqd_ptr_w(DEPTH)-1:0]    wr_addr,
    input  logic [DATA_WIDTH-1:0]                   wr_data,
    input  logic                                    rd_en,
    input  logic [fqd_pkg::fqd_ptr_w(DEPTH)-1:0]    rd_addr,
    output logic [DATA_WIDTH-1:0]                   rd_data
);
    import fqd_pkg::*;

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/fqd_ctrl.sv @@
// ----------------------------------------------------------------------------
// fqd_ctrl
// request sequencer: ring pointers, occupancy, search and close-up shift
// ----------------------------------------------------------------------------
module fqd_ctrl #(
    parameter int DEPTH      = fqd_pkg::FQD_DEPTH,
    parameter int DATA_WIDTH = fqd_pkg::FQD_DATA_WIDTH
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    req_valid,
    output logic                                    req_ready,
    input  logic [fqd_pkg::REQ_W-1:0]               req_type,
    input  logic [fqd_pkg::ITEM_W-1:0]              value,
    output logic                                    wr_en,
    output logic [fqd_pkg::fqd_ptr_w(DEPTH)-1:0]    wr_addr,
    output logic [DATA_WIDTH-1:0]                   wr_data,
    output logic                                    rd_en,
    output logic [fqd_pkg::fqd_ptr_w(DEPTH)-1:0]    rd_addr,
    input  logic [DATA_WIDTH-1:0]                   rd_data,
    input  logic                                    load_ok,
    output logic                                    res_load,
    output fqd_pkg::fqd_res_t                       res
);
    import fqd_pkg::*;

    localparam int PTR_W = fqd_ptr_w(DEPTH);
    localparam int CNT_W = fqd_cnt_w(DEPTH);

    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_RESP      = 3'd1;
    localparam logic [2:0] ST_DEQ_CAP   = 3'd2;
    localparam logic [2:0] ST_ITER      = 3'd3;
    localparam logic [2:0] ST_DEL_SCAN  = 3'd4;
    localparam logic [2:0] ST_DEL_SHIFT = 3'd5;

    logic [2:0]            state_reg, state_next;
    logic [PTR_W-1:0]      head_reg, head_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [PTR_W-1:0]      idx_reg, idx_next;
    logic [DATA_WIDTH-1:0] word_reg, word_next;
    logic                  res_status_reg, res_status_next;
    logic                  res_valid_reg, res_valid_next;
    logic [ITEM_W-1:0]     res_data_reg, res_data_next;

    logic [63:0]           value_ext;
    logic [63:0]           rd_ext;
    logic [63:0]           cnt_ext;
    logic [DATA_WIDTH-1:0] value_word;
    logic [ITEM_W-1:0]     rd_item;
    logic                  is_full;
    logic                  is_empty;
    logic                  idx_last;

    // logical position to ring address
    function automatic logic [PTR_W-1:0] phys(input logic [PTR_W-1:0] head,
                                              input logic [PTR_W-1:0] pos);
        logic [PTR_W:0] sum;
        sum = {1'b0, head} + {1'b0, pos};
        if (sum >= (PTR_W+1)'(DEPTH))
        begin
            sum = sum - (PTR_W+1)'(DEPTH);
        end
        return sum[PTR_W-1:0];
    endfunction

    assign value_ext  = 64'(value);
    assign value_word = value_ext[DATA_WIDTH-1:0];
    assign rd_ext     = 64'(rd_data);
    assign rd_item    = rd_ext[ITEM_W-1:0];
    assign cnt_ext    = 64'(cnt_reg);
    assign is_full    = (cnt_reg == CNT_W'(DEPTH));
    assign is_empty   = (cnt_reg == '0);
    assign idx_last   = ((CNT_W'(idx_reg) + CNT_W'(1)) == cnt_reg);

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        cnt_next        = cnt_reg;
        idx_next        = idx_reg;
        word_next       = word_reg;
        res_status_next = res_status_reg;
        res_valid_next  = res_valid_reg;
        res_data_next   = res_data_reg;
        req_ready       = 1'b0;
        wr_en           = 1'b0;
        wr_addr         = phys(head_reg, cnt_reg[PTR_W-1:0]);
        wr_data         = value_word;
        rd_en           = 1'b0;
        rd_addr         = head_reg;
        res_load        = 1'b0;
        res.status      = res_status_reg;
        res.item_valid  = res_valid_reg;
        res.item_data   = res_data_reg;
        res.entry_count = cnt_ext[COUNT_W-1:0];
        res.last        = 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    word_next       = value_word;
                    idx_next        = '0;
                    res_status_next = 1'b0;
                    res_valid_next  = 1'b0;
                    res_data_next   = '0;
                    state_next      = ST_RESP;
                    unique case (req_type)
                        REQ_ENQUEUE:
                        begin
                            if (is_full)
                            begin
                                res_status_next = 1'b1;
                            end
                            else
                            begin
                                wr_en    = 1'b1;
                                cnt_next = cnt_reg + CNT_W'(1);
                            end
                        end
                        REQ_DEQUEUE:
                        begin
                            if (is_empty)
                            begin
                                res_status_next = 1'b1;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                state_next = ST_DEQ_CAP;
                            end
                        end
                        REQ_DELETE:
                        begin
                            if (is_empty || value_word == '0)
                            begin
                                res_status_next = 1'b1;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                state_next = ST_DEL_SCAN;
                            end
                        end
                        REQ_ITERATE:
                        begin
                            if (!is_empty)
                            begin
                                rd_en      = 1'b1;
                                state_next = ST_ITER;
                            end
                        end
                        REQ_LENGTH:
                        begin
                            res_status_next = 1'b0;
                        end
                        default:
                        begin
                            res_status_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_DEQ_CAP:
            begin
                res_data_next  = rd_item;
                res_valid_next = 1'b1;
                head_next      = phys(head_reg, PTR_W'(1));
                cnt_next       = cnt_reg - CNT_W'(1);
                state_next     = ST_RESP;
            end
            ST_RESP:
            begin
                if (load_ok)
                begin
                    res_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_ITER:
            begin
                res.status     = 1'b0;
                res.item_valid = 1'b1;
                res.item_data  = rd_item;
                res.last       = idx_last;
                if (load_ok)
                begin
                    res_load = 1'b1;
                    if (idx_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        // next read issued with this beat, one entry per cycle while the output register takes beats
                        rd_en    = 1'b1;
                        rd_addr  = phys(head_reg, idx_reg + PTR_W'(1));
                        idx_next = idx_reg + PTR_W'(1);
                    end
                end
            end
            ST_DEL_SCAN:
            begin
                if (idx_last)
                begin
                    state_next = ST_RESP;
                    if (rd_data == word_reg)
                    begin
                        res_status_next = 1'b0;
                        cnt_next        = cnt_reg - CNT_W'(1);
                    end
                    else
                    begin
                        res_status_next = 1'b1;
                    end
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_addr  = phys(head_reg, idx_reg + PTR_W'(1));
                    idx_next = idx_reg + PTR_W'(1);
                    if (rd_data == word_reg)
                    begin
                        state_next = ST_DEL_SHIFT;
                    end
                end
            end
            ST_DEL_SHIFT:
            begin
                // write goes one slot below the read, so the two never collide
                wr_en   = 1'b1;
                wr_addr = phys(head_reg, idx_reg - PTR_W'(1));
                wr_data = rd_data;
                if (idx_last)
                begin
                    res_status_next = 1'b0;
                    cnt_next        = cnt_reg - CNT_W'(1);
                    state_next      = ST_RESP;
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_addr  = phys(head_reg, idx_reg + PTR_W'(1));
                    idx_next = idx_reg + PTR_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            head_reg  <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        word_reg       <= word_next;
        res_status_reg <= res_status_next;
        res_valid_reg  <= res_valid_next;
        res_data_reg   <= res_data_next;
    end

endmodule

@@ rtl/fqd_outreg.sv @@
// ----------------------------------------------------------------------------
// fqd_outreg
// result register between the sequencer and the response channel
// ----------------------------------------------------------------------------
module fqd_outreg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        res_load,
    input  fqd_pkg::fqd_res_t           res,
    output logic                        load_ok,
    output logic                        rsp_valid,
    input  logic                        rsp_ready,
    output logic                        status,
    output logic                        item_valid,
    output logic [fqd_pkg::ITEM_W-1:0]  item_data,
    output logic [fqd_pkg::COUNT_W-1:0] entry_count,
    output logic                        last
);
    import fqd_pkg::*;

    logic     valid_reg, valid_next;
    fqd_res_t beat_reg;

    // free now, or the held beat leaves this cycle
    assign load_ok = !valid_reg || rsp_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load_ok)
        begin
            valid_next = res_load;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_ok && res_load)
        begin
            beat_reg <= res;
        end
    end

    assign rsp_valid   = valid_reg;
    assign status      = beat_reg.status;
    assign item_valid  = beat_reg.item_valid;
    assign item_data   = beat_reg.item_data;
    assign entry_count = beat_reg.entry_count;
    assign last        = beat_reg.last;

endmodule

@@ rtl/fifo_queue_with_delete.sv @@
// enqueue, length and rejected requests go from the response state into the output register;
//   dequeue passes the capture state first; iterate streams one entry per cycle after the memory
//   read, while the output register can take each beat. delete scans one entry per cycle, then
//   closes the gap one entry per cycle, bound by the single read port of the entry memory.
// next request is taken the cycle after the last beat loads.
// reset clears occupancy, head pointer and sequencer state; the entry memory is not cleared.
// ----------------------------------------------------------------------------
// fifo_queue_with_delete
// bounded ring-buffer queue with dequeue, delete-by-value, iterate and length
// ----------------------------------------------------------------------------
`include "fifo_queue_with_delete_macros.svh"

module fifo_queue_with_delete #(
    parameter int DEPTH      = fqd_pkg::FQD_DEPTH,
    parameter int DATA_WIDTH = fqd_pkg::FQD_DATA_WIDTH
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_ready,
    input  logic [fqd_pkg::REQ_W-1:0]   req_type,
    input  logic [fqd_pkg::ITEM_W-1:0]  value,
    output logic                        rsp_valid,
    input  logic                        rsp_ready,
    output logic                        status,
    output logic                        item_valid,
    output logic [fqd_pkg::ITEM_W-1:0]  item_data,
    output logic [fqd_pkg::COUNT_W-1:0] entry_count,
    output logic                        last
);
    import fqd_pkg::*;

    localparam int PTR_W = fqd_ptr_w(DEPTH);

    logic                  wr_en;
    logic [PTR_W-1:0]      wr_addr;
    logic [DATA_WIDTH-1:0] wr_data;
    logic                  rd_en;
    logic [PTR_W-1:0]      rd_addr;
    logic [DATA_WIDTH-1:0] rd_data;
    logic                  load_ok;
    logic                  res_load;
    fqd_res_t              res;

    fqd_store #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    fqd_ctrl #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_type  (req_type),
        .value     (value),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .load_ok   (load_ok),
        .res_load  (res_load),
        .res       (res)
    );

    fqd_outreg u_outreg (
        .clk         (clk),
        .rst_n       (rst_n),
        .res_load    (res_load),
        .res         (res),
        .load_ok     (load_ok),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .status      (status),
        .item_valid  (item_valid),
        .item_data   (item_data),
        .entry_count (entry_count),
        .last        (last)
    );

    // an entry is only returned by a successful request
    `FQD_ASSERT_IMP(a_item_ok, clk, rst_n, rsp_valid && item_valid, !status)
    // empty beats carry zero data
    `FQD_ASSERT_IMP(a_empty_zero, clk, rst_n, rsp_valid && !item_valid, item_data == '0)
    // a failed request ends with its only beat
    `FQD_ASSERT_IMP(a_err_last, clk, rst_n, rsp_valid && status, last)
    // one request at a time: the sequencer leaves idle on acceptance
    `FQD_ASSERT_NEXT(a_busy, clk, rst_n, req_valid && req_ready, !req_ready)

endmodule

@@ bench/fqd_queue_checker.sv @@
// ----------------------------------------------------------------------------
// fqd_queue_checker
// watches the request and response channels, keeps a shadow of the queue and
// compares every response beat with the beat the shadow predicts
// ----------------------------------------------------------------------------
module fqd_queue_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    input  logic                        req_ready,
    input  logic [fqd_pkg::REQ_W-1:0]   req_type,
    input  logic [fqd_pkg::ITEM_W-1:0]  value,
    input  logic                        rsp_valid,
    input  logic                        rsp_ready,
    input  logic                        status,
    input  logic                        item_valid,
    input  logic [fqd_pkg::ITEM_W-1:0]  item_data,
    input  logic [fqd_pkg::COUNT_W-1:0] entry_count,
    input  logic                        last,
    output int                          fail_count,
    output int                          outstanding,
    output int                          beats_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import fqd_pkg::*;

    localparam logic ST_OK  = 1'b0;
    localparam logic ST_ERR = 1'b1;

    logic [ITEM_W-1:0] shadow_words[$];
    fqd_res_t          pending_beats[$];
    int                n_fail  = 0;
    int                n_beats = 0;

    function automatic fqd_res_t make_beat(logic st, logic iv, logic [ITEM_W-1:0] d,
                                           logic lst);
        fqd_res_t b;
        b.status      = st;
        b.item_valid  = iv;
        b.item_data   = d;
        b.entry_count = COUNT_W'(shadow_words.size());
        b.last        = lst;
        return b;
    endfunction

    // updates the shadow queue and queues the beats this request must produce
    function automatic void apply_request(logic [REQ_W-1:0] kind, logic [ITEM_W-1:0] word);
        int                i;
        int                hit;
        logic [ITEM_W-1:0] head;
        hit = -1;
        case (kind)
            REQ_ENQUEUE:
                if (shadow_words.size() >= FQD_DEPTH)
                    pending_beats.push_back(make_beat(ST_ERR, 1'b0, '0, 1'b1));
                else
                begin
                    shadow_words.push_back(word);
                    pending_beats.push_back(make_beat(ST_OK, 1'b0, '0, 1'b1));
                end
            REQ_DEQUEUE:
                if (shadow_words.size() == 0)
                    pending_beats.push_back(make_beat(ST_ERR, 1'b0, '0, 1'b1));
                else
                begin
                    head = shadow_words.pop_front();
                    pending_beats.push_back(make_beat(ST_OK, 1'b1, head, 1'b1));
                end
            REQ_DELETE:
            begin
                // zero key never matches; otherwise the oldest equal entry goes
                if (word != '0)
                    for (i = 0; i < shadow_words.size() && hit < 0; i++)
                        if (shadow_words[i] == word)
                            hit = i;
                if (hit >= 0)
                begin
                    shadow_words.delete(hit);
                    pending_beats.push_back(make_beat(ST_OK, 1'b0, '0, 1'b1));
                end
                else
                    pending_beats.push_back(make_beat(ST_ERR, 1'b0, '0, 1'b1));
            end
            REQ_ITERATE:
                if (shadow_words.size() == 0)
                    pending_beats.push_back(make_beat(ST_OK, 1'b0, '0, 1'b1));
                else
                    for (i = 0; i < shadow_words.size(); i++)
                        pending_beats.push_back(make_beat(ST_OK, 1'b1, shadow_words[i],
                                                          i == shadow_words.size() - 1));
            REQ_LENGTH:
                pending_beats.push_back(make_beat(ST_OK, 1'b0, '0, 1'b1));
            default:
                pending_beats.push_back(make_beat(ST_ERR, 1'b0, '0, 1'b1));
        endcase
    endfunction

    function automatic void check_beat();
        fqd_res_t want;
        if (pending_beats.size() == 0)
        begin
            n_fail++;
            if (n_fail <= 10)
                $display("%0t: beat with nothing expected: status=%0b valid=%0b data=%h count=%0d last=%0b",
                         $realtime, status, item_valid, item_data, entry_count, last);
        end
        else
        begin
            want = pending_beats.pop_front();
            n_beats++;
            if (status !== want.status || item_valid !== want.item_valid ||
                item_data !== want.item_data || entry_count !== want.entry_count ||
                last !== want.last)
            begin
                n_fail++;
                if (n_fail <= 10)
                    $display("%0t: beat mismatch exp status=%0b valid=%0b data=%h count=%0d last=%0b | got status=%0b valid=%0b data=%h count=%0d last=%0b",
                             $realtime, want.status, want.item_valid, want.item_data,
                             want.entry_count, want.last, status, item_valid, item_data,
                             entry_count, last);
            end
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            // responses first: a beat seen at the edge a request is taken is an older one
            if (rsp_valid && rsp_ready)
                check_beat();
            if (req_valid && req_ready)
                apply_request(req_type, value);
        end
        fail_count    <= n_fail;
        outstanding   <= pending_beats.size();
        beats_checked <= n_beats;
    end

endmodule

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// drives requests into the queue under several idle and stall mixes; the
// checker beside the block predicts and compares every response beat
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fqd_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNUSED_FIRST = REQ_LENGTH + 3'd1;
    localparam logic [REQ_W-1:0] REQ_UNUSED_LAST  = '1;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                req_valid = 1'b0;
    logic [REQ_W-1:0]    req_type  = REQ_LENGTH;
    logic [ITEM_W-1:0]   value     = '0;
    logic                rsp_ready = 1'b0;
    logic                req_ready;
    logic                rsp_valid;
    logic                status;
    logic                item_valid;
    logic [ITEM_W-1:0]   item_data;
    logic [COUNT_W-1:0]  entry_count;
    logic                last;

    int                  fail_count;
    int                  outstanding;
    int                  beats_checked;
    int                  idle_pct  = 0;
    int                  stall_pct = 0;
    int                  kind_sent[8];
    logic [ITEM_W-1:0]   recent_word = 32'd1;

    fifo_queue_with_delete u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req_type    (req_type),
        .value       (value),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .status      (status),
        .item_valid  (item_valid),
        .item_data   (item_data),
        .entry_count (entry_count),
        .last        (last)
    );

    fqd_queue_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_ready     (req_ready),
        .req_type      (req_type),
        .value         (value),
        .rsp_valid     (rsp_valid),
        .rsp_ready     (rsp_ready),
        .status        (status),
        .item_valid    (item_valid),
        .item_data     (item_data),
        .entry_count   (entry_count),
        .last          (last),
        .fail_count    (fail_count),
        .outstanding   (outstanding),
        .beats_checked (beats_checked)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
        rsp_ready <= ($urandom_range(99) >= stall_pct);

    // valid is only dropped when an idle gap is taken, so it never toggles within a step
    task automatic send_req(input logic [REQ_W-1:0] kind, input logic [ITEM_W-1:0] word);
        if (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            req_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < idle_pct);
        end
        req_valid <= 1'b1;
        req_type  <= kind;
        value     <= word;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        kind_sent[kind]++;
        if (kind == REQ_ENQUEUE)
            recent_word = word;
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // small keys make delete hits and duplicates common
    function automatic logic [ITEM_W-1:0] pick_word();
        int r;
        r = $urandom_range(99);
        if (r < 45)
            return ITEM_W'($urandom_range(6, 1));
        else if (r < 55)
            return '0;
        else if (r < 62)
            return '1;
        else if (r < 72)
            return recent_word;
        else
            return $urandom;
    endfunction

    function automatic logic [REQ_W-1:0] REQ_TYPE_RAND();
        return REQ_W'($urandom_range(REQ_UNUSED_LAST, REQ_UNUSED_FIRST));
    endfunction

    function automatic logic [REQ_W-1:0] pick_kind(input int enq_weight);
        int r;
        if ($urandom_range(99) < enq_weight)
            return REQ_ENQUEUE;
        r = $urandom_range(99);
        if (r < 35)
            return REQ_DEQUEUE;
        else if (r < 70)
            return REQ_DELETE;
        else if (r < 85)
            return REQ_ITERATE;
        else if (r < 95)
            return REQ_LENGTH;
        else
            return REQ_TYPE_RAND();
    endfunction

    initial
    begin
        int                phase;
        int                half;
        int                n;
        int                wait_cycles;
        int                unused_total;
        logic [REQ_W-1:0]  code;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty-queue corner cases and unknown request codes
        send_req(REQ_LENGTH, '0);
        send_req(REQ_DEQUEUE, '1);
        send_req(REQ_ITERATE, '0);
        send_req(REQ_DELETE, '0);
        send_req(REQ_DELETE, 32'h0000_1234);
        for (code = REQ_UNUSED_FIRST; code != REQ_UNUSED_LAST; code++)
            send_req(code, '1);
        send_req(REQ_UNUSED_LAST, '0);

        // fill to the brim with duplicates and a unique tail entry
        send_req(REQ_ENQUEUE, '0);
        send_req(REQ_ENQUEUE, '1);
        send_req(REQ_ENQUEUE, 32'h5555_5555);
        send_req(REQ_ENQUEUE, 32'hAAAA_AAAA);
        for (n = 0; n < FQD_DEPTH - 5; n++)
            send_req(REQ_ENQUEUE, ITEM_W'(n % 6 + 1));
        send_req(REQ_ENQUEUE, 32'hFFFF_0001);
        send_req(REQ_ENQUEUE, 32'h0000_0077);
        send_req(REQ_ITERATE, '0);
        send_req(REQ_DELETE, 32'hFFFF_0001);
        send_req(REQ_DELETE, 32'd3);
        send_req(REQ_DELETE, '0);
        send_req(REQ_DEQUEUE, '0);
        send_req(REQ_ITERATE, '1);
        wait_drained();

        // random traffic: filling then draining bias under each idle/stall mix
        for (phase = 0; phase < 4; phase++)
        begin
            idle_pct  = (phase == 1) ? 86 : (phase == 3) ? 14 : 0;
            stall_pct = (phase == 2) ? 86 : (phase == 3) ? 14 : 0;
            for (half = 0; half < 2; half++)
                for (n = 0; n < 47; n++)
                    send_req(pick_kind(half == 0 ? 55 : 15), pick_word());
            wait_drained();
        end

        req_valid <= 1'b0;
        for (wait_cycles = 0; outstanding != 0 && wait_cycles < 20000; wait_cycles++)
            @(posedge clk);
        repeat (40) @(posedge clk);

        unused_total = 0;
        for (n = REQ_UNUSED_FIRST; n <= REQ_UNUSED_LAST; n++)
            unused_total += kind_sent[n];
        $display("requests: %0d enqueue, %0d dequeue, %0d delete, ",
                 kind_sent[REQ_ENQUEUE], kind_sent[REQ_DEQUEUE], kind_sent[REQ_DELETE],
                 "%0d iterate, %0d length, %0d unknown code",
                 kind_sent[REQ_ITERATE], kind_sent[REQ_LENGTH], unused_total);
        $display("%0d response beats compared over free-running, sender-idle, ",
                 beats_checked, "receiver-stall and mixed phases");
        if (outstanding != 0)
            $display("%0d expected beats never arrived", outstanding);
        if (fail_count == 0 && outstanding == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("timeout with %0d beats still expected", outstanding);
        $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ fifo_queue_with_delete.f @@
+incdir+rtl
rtl/fqd_pkg.sv
rtl/fqd_store.sv
rtl/fqd_ctrl.sv
rtl/fqd_outreg.sv
rtl/fifo_queue_with_delete.sv
bench/fqd_queue_checker.sv
bench/tb.sv
